### hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache table
// Transaction payloads, scan chain records, update commands and FSM states.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CAP_W          = 5;
  localparam int unsigned KEY_W          = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [KEY_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [KEY_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

  // Summary flags carried along the scan chain
  typedef struct packed {
    logic found;
    logic have_vic;
    logic have_free;
  } scan_flags_t;

  // Update broadcast to every cell at writeback
  typedef struct packed {
    logic             upd;
    logic             insert;
    logic             wr_val;
    logic             age_all;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

### hw/rtl/lfu_cell.sv
// ----------------------------------------------------------------------------
// lfu_cell: one slot of the LFU cache table
// Holds key, value, use count and recency rank of one slot, merges its slot
// into the scan record passing down the chain, and applies writeback updates.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int unsigned IDX        = 0,
  localparam int unsigned IW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [lfu_pkg::KEY_W-1:0] key_i,
  // Record from the previous cell
  input  lfu_pkg::scan_flags_t     flags_i,
  input  logic [IW-1:0]            hit_idx_i,
  input  logic [IW-1:0]            hit_rank_i,
  input  logic [lfu_pkg::KEY_W-1:0] hit_value_i,
  input  logic [IW-1:0]            vic_idx_i,
  input  logic [IW-1:0]            vic_rank_i,
  input  logic [COUNT_BITS-1:0]    vic_cnt_i,
  input  logic [lfu_pkg::KEY_W-1:0] vic_key_i,
  input  logic [IW-1:0]            free_idx_i,
  // Record to the next cell, registered
  output lfu_pkg::scan_flags_t     flags_o,
  output logic [IW-1:0]            hit_idx_o,
  output logic [IW-1:0]            hit_rank_o,
  output logic [lfu_pkg::KEY_W-1:0] hit_value_o,
  output logic [IW-1:0]            vic_idx_o,
  output logic [IW-1:0]            vic_rank_o,
  output logic [COUNT_BITS-1:0]    vic_cnt_o,
  output logic [lfu_pkg::KEY_W-1:0] vic_key_o,
  output logic [IW-1:0]            free_idx_o,
  // Writeback broadcast
  input  lfu_pkg::cmd_t            cmd_i,
  input  logic [IW-1:0]            tgt_i,
  input  logic [IW-1:0]            old_rank_i
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                      valid_q, valid_d;
  logic [lfu_pkg::KEY_W-1:0] key_q, key_d;
  logic [lfu_pkg::KEY_W-1:0] val_q, val_d;
  logic [COUNT_BITS-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]             rank_q, rank_d;

  lfu_pkg::scan_flags_t      flags_q, flags_d;
  logic [IW-1:0]             hit_idx_q, hit_idx_d, hit_rank_q, hit_rank_d;
  logic [lfu_pkg::KEY_W-1:0] hit_value_q, hit_value_d;
  logic [IW-1:0]             vic_idx_q, vic_idx_d, vic_rank_q, vic_rank_d;
  logic [COUNT_BITS-1:0]     vic_cnt_q, vic_cnt_d;
  logic [lfu_pkg::KEY_W-1:0] vic_key_q, vic_key_d;
  logic [IW-1:0]             free_idx_q, free_idx_d;

  logic match, better;

  // Merge this slot into the passing record
  always_comb begin
    match  = valid_q && (key_q == key_i);
    better = valid_q && (!flags_i.have_vic || (cnt_q < vic_cnt_i) ||
             ((cnt_q == vic_cnt_i) && (rank_q > vic_rank_i)));
    flags_d     = flags_i;
    hit_idx_d   = hit_idx_i;
    hit_rank_d  = hit_rank_i;
    hit_value_d = hit_value_i;
    vic_idx_d   = vic_idx_i;
    vic_rank_d  = vic_rank_i;
    vic_cnt_d   = vic_cnt_i;
    vic_key_d   = vic_key_i;
    free_idx_d  = free_idx_i;
    if (!flags_i.found && match) begin
      flags_d.found = 1'b1;
      hit_idx_d     = MY_IDX;
      hit_rank_d    = rank_q;
      hit_value_d   = val_q;
    end
    if (better) begin
      flags_d.have_vic = 1'b1;
      vic_idx_d        = MY_IDX;
      vic_rank_d       = rank_q;
      vic_cnt_d        = cnt_q;
      vic_key_d        = key_q;
    end
    if (!flags_i.have_free && !valid_q) begin
      flags_d.have_free = 1'b1;
      free_idx_d        = MY_IDX;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q     <= flags_d;
    hit_idx_q   <= hit_idx_d;
    hit_rank_q  <= hit_rank_d;
    hit_value_q <= hit_value_d;
    vic_idx_q   <= vic_idx_d;
    vic_rank_q  <= vic_rank_d;
    vic_cnt_q   <= vic_cnt_d;
    vic_key_q   <= vic_key_d;
    free_idx_q  <= free_idx_d;
  end

  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_rank_o  = hit_rank_q;
  assign hit_value_o = hit_value_q;
  assign vic_idx_o   = vic_idx_q;
  assign vic_rank_o  = vic_rank_q;
  assign vic_cnt_o   = vic_cnt_q;
  assign vic_key_o   = vic_key_q;
  assign free_idx_o  = free_idx_q;

  // Apply writeback: the target becomes most recent, younger slots (all valid slots with age_all) age by one
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    rank_d  = rank_q;
    if (cmd_i.upd) begin
      if (tgt_i == MY_IDX) begin
        valid_d = 1'b1;
        rank_d  = '0;
        if (cmd_i.insert) begin
          key_d = cmd_i.key;
          val_d = cmd_i.value;
          cnt_d = COUNT_BITS'(1);
        end else begin
          if (cmd_i.wr_val) begin
            val_d = cmd_i.value;
          end
          if (cnt_q != '1) begin
            cnt_d = cnt_q + COUNT_BITS'(1);
          end
        end
      end else if (valid_q && (cmd_i.age_all || (rank_q < old_rank_i))) begin
        rank_d = rank_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    val_q  <= val_d;
    cnt_q  <= cnt_d;
    rank_q <= rank_d;
  end

endmodule

### hw/rtl/lfu_cache_table.sv
// The scan record walks the cell chain one cell a cycle; then the writeback follows,
// held off while an earlier result waits unaccepted, and the next input transaction
// is taken in the idle state after it, so one transaction is processed at a time.
// A finished result waits in an output register while the next input is taken.
// Reset clears all slot valid bits, occupancy and control; capacity resets to 16.
// ----------------------------------------------------------------------------
// lfu_cache_table: key/value cache with LFU replacement, LRU tie-break
// A chain of slot cells scans for key match, eviction victim and free slot;
// the controller then broadcasts at most one update to all cells.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
  parameter int unsigned ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lfu_pkg::req_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lfu_pkg::rsp_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_data_i
);

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW  = $clog2(ENTRIES + 1);
  localparam int unsigned CW  = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;
  localparam int unsigned KW  = lfu_pkg::KEY_W;

  lfu_pkg::state_e      state_q, state_d;
  logic [IW-1:0]        cnt_q, cnt_d;
  lfu_pkg::req_t        req_q;
  logic [lfu_pkg::CAP_W-1:0] capacity_q;
  logic [OW-1:0]        occ_q, occ_d;
  logic                 out_valid_q, out_valid_d;
  lfu_pkg::rsp_t        out_q, rsp;
  logic                 go;

  // Scan chain wires
  lfu_pkg::scan_flags_t flags_w [ENTRIES];
  logic [IW-1:0]        hit_idx_w [ENTRIES];
  logic [IW-1:0]        hit_rank_w [ENTRIES];
  logic [KW-1:0]        hit_value_w [ENTRIES];
  logic [IW-1:0]        vic_idx_w [ENTRIES];
  logic [IW-1:0]        vic_rank_w [ENTRIES];
  logic [COUNT_BITS-1:0] vic_cnt_w [ENTRIES];
  logic [KW-1:0]        vic_key_w [ENTRIES];
  logic [IW-1:0]        free_idx_w [ENTRIES];

  lfu_pkg::cmd_t        cmd;
  logic [IW-1:0]        tgt, old_rank;
  logic [CW-1:0]        cap_ext, cap_eff, occ_ext;
  logic                 is_put;

  // Build the cell chain
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      lfu_cell #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS), .IDX(g)) u_cell (
        .clk_i, .rst_ni,
        .key_i       (req_q.lookup_key),
        .flags_i     ('0),
        .hit_idx_i   ('0),
        .hit_rank_i  ('0),
        .hit_value_i ('0),
        .vic_idx_i   ('0),
        .vic_rank_i  ('0),
        .vic_cnt_i   ('0),
        .vic_key_i   ('0),
        .free_idx_i  ('0),
        .flags_o     (flags_w[g]),
        .hit_idx_o   (hit_idx_w[g]),
        .hit_rank_o  (hit_rank_w[g]),
        .hit_value_o (hit_value_w[g]),
        .vic_idx_o   (vic_idx_w[g]),
        .vic_rank_o  (vic_rank_w[g]),
        .vic_cnt_o   (vic_cnt_w[g]),
        .vic_key_o   (vic_key_w[g]),
        .free_idx_o  (free_idx_w[g]),
        .cmd_i       (cmd),
        .tgt_i       (tgt),
        .old_rank_i  (old_rank)
      );
    end else begin : g_body
      lfu_cell #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS), .IDX(g)) u_cell (
        .clk_i, .rst_ni,
        .key_i       (req_q.lookup_key),
        .flags_i     (flags_w[g-1]),
        .hit_idx_i   (hit_idx_w[g-1]),
        .hit_rank_i  (hit_rank_w[g-1]),
        .hit_value_i (hit_value_w[g-1]),
        .vic_idx_i   (vic_idx_w[g-1]),
        .vic_rank_i  (vic_rank_w[g-1]),
        .vic_cnt_i   (vic_cnt_w[g-1]),
        .vic_key_i   (vic_key_w[g-1]),
        .free_idx_i  (free_idx_w[g-1]),
        .flags_o     (flags_w[g]),
        .hit_idx_o   (hit_idx_w[g]),
        .hit_rank_o  (hit_rank_w[g]),
        .hit_value_o (hit_value_w[g]),
        .vic_idx_o   (vic_idx_w[g]),
        .vic_rank_o  (vic_rank_w[g]),
        .vic_cnt_o   (vic_cnt_w[g]),
        .vic_key_o   (vic_key_w[g]),
        .free_idx_o  (free_idx_w[g]),
        .cmd_i       (cmd),
        .tgt_i       (tgt),
        .old_rank_i  (old_rank)
      );
    end
  end

  // Decide the writeback from the completed scan record
  always_comb begin
    cap_ext  = CW'(capacity_q);
    cap_eff  = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
    occ_ext  = CW'(occ_q);
    is_put   = (req_q.opcode == lfu_pkg::OP_PUT);
    go       = (state_q == lfu_pkg::ST_UPDATE) && (!out_valid_q || out_ready_i);
    cmd        = '0;
    cmd.key    = req_q.lookup_key;
    cmd.value  = req_q.write_value;
    tgt        = hit_idx_w[ENTRIES-1];
    old_rank   = hit_rank_w[ENTRIES-1];
    occ_d      = occ_q;
    rsp        = '0;
    rsp.hit    = flags_w[ENTRIES-1].found;
    if (!is_put) begin
      if (flags_w[ENTRIES-1].found) begin
        rsp.read_value = hit_value_w[ENTRIES-1];
        cmd.upd        = go;
      end
    end else if (cap_eff != '0) begin
      if (flags_w[ENTRIES-1].found) begin
        cmd.upd    = go;
        cmd.wr_val = 1'b1;
      end else if (occ_ext >= cap_eff) begin
        cmd.upd         = go;
        cmd.insert      = 1'b1;
        tgt             = vic_idx_w[ENTRIES-1];
        old_rank        = vic_rank_w[ENTRIES-1];
        rsp.evicted     = 1'b1;
        rsp.evicted_key = vic_key_w[ENTRIES-1];
      end else begin
        cmd.upd     = go;
        cmd.insert  = 1'b1;
        cmd.age_all = 1'b1;
        tgt         = free_idx_w[ENTRIES-1];
        if (go) begin
          occ_d = occ_q + OW'(1);
        end
      end
    end
  end

  // Sequence: idle, scan the chain, write back
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      lfu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = lfu_pkg::ST_SCAN;
          cnt_d   = '0;
        end
      end
      lfu_pkg::ST_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(ENTRIES - 1)) begin
          state_d = lfu_pkg::ST_UPDATE;
        end
      end
      lfu_pkg::ST_UPDATE: begin
        if (go) begin
          state_d     = lfu_pkg::ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfu_pkg::ST_IDLE;
      cnt_q       <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      capacity_q  <= lfu_pkg::CAP_RESET;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
    end
  end

  // Hold request and result payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (go) begin
      out_q <= rsp;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/lfu_checker.sv
// ----------------------------------------------------------------------------
// lfu_checker: port-level assertions for the LFU cache table
// Watches result transactions and input handshake behavior over time.
// ----------------------------------------------------------------------------
module lfu_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input lfu_pkg::rsp_t out_data_o
);

  // Stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // Block is busy right after taking an input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !($rose(out_valid_o)))
    else $error("input taken while a scan was running");

  // A hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.evicted))
    else $error("hit with eviction");

  // Unused result fields read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.evicted || out_data_o.evicted_key == '0) &&
                    (out_data_o.hit || out_data_o.read_value == '0))
    else $error("nonzero field without hit or eviction");

endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### tb/lfu_cache_table_tb.sv
// ----------------------------------------------------------------------------
// lfu_cache_table_tb: self-checking bench for the LFU cache table
// Drives get/put transactions with random handshake gaps, predicts each
// response with a behavioral LFU/LRU cache and compares field by field.
// Capacity is changed between phases only while the table is idle.
// ----------------------------------------------------------------------------
module lfu_cache_table_tb;

  localparam int NSLOT = 16;
  localparam int COUNT_MAX = 65535;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  lfu_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  lfu_pkg::rsp_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [lfu_pkg::CAP_W-1:0] cfg_data_i;

  lfu_cache_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Shadow cache state
  logic [lfu_pkg::CAP_W-1:0] cap_shadow;
  bit               sh_valid [NSLOT];
  logic [31:0]      sh_key   [NSLOT];
  logic [31:0]      sh_value [NSLOT];
  int unsigned      sh_count [NSLOT];
  int unsigned      sh_rank  [NSLOT];
  int unsigned      sh_occ;

  lfu_pkg::req_t pending_reqs[$];
  lfu_pkg::rsp_t expected_rsps[$];
  int   errors;
  int   responses_seen;
  int   evictions_seen;
  int   hits_seen;
  int   idle_cycles;
  bit   no_gaps;
  int   in_gap;
  int   out_gap;
  bit   in_acc;

  function automatic void touch_slot(input int s);
    int i;
    for (i = 0; i < NSLOT; i++)
      if (sh_valid[i] && i != s && sh_rank[i] < sh_rank[s]) sh_rank[i]++;
    sh_rank[s] = 0;
    if (sh_count[s] < COUNT_MAX) sh_count[s]++;
  endfunction

  // Apply one transaction to the shadow cache and return its response
  function automatic lfu_pkg::rsp_t cache_access(input lfu_pkg::req_t rq);
    lfu_pkg::rsp_t r;
    int i, hs, dest, v, cap;
    bit found, have;
    r = '0;
    found = 0;
    hs = 0;
    cap = (cap_shadow > NSLOT) ? NSLOT : cap_shadow;
    for (i = 0; i < NSLOT; i++)
      if (!found && sh_valid[i] && sh_key[i] == rq.lookup_key) begin
        found = 1;
        hs = i;
      end
    r.hit = found;
    if (rq.opcode == lfu_pkg::OP_GET) begin
      if (found) begin
        r.read_value = sh_value[hs];
        touch_slot(hs);
      end
      return r;
    end
    if (cap == 0) return r;
    if (found) begin
      sh_value[hs] = rq.write_value;
      touch_slot(hs);
      return r;
    end
    dest = 0;
    if (sh_occ >= cap) begin
      have = 0;
      v = 0;
      for (i = 0; i < NSLOT; i++) begin
        if (!sh_valid[i]) continue;
        if (!have || sh_count[i] < sh_count[v] ||
            (sh_count[i] == sh_count[v] && sh_rank[i] > sh_rank[v])) begin
          have = 1;
          v = i;
        end
      end
      if (have) begin
        r.evicted = 1'b1;
        r.evicted_key = sh_key[v];
        sh_valid[v] = 0;
        for (i = 0; i < NSLOT; i++)
          if (sh_valid[i] && sh_rank[i] > sh_rank[v]) sh_rank[i]--;
        if (sh_occ > 0) sh_occ--;
        dest = v;
      end
    end else begin
      for (i = NSLOT - 1; i >= 0; i--)
        if (!sh_valid[i]) dest = i;
    end
    for (i = 0; i < NSLOT; i++)
      if (sh_valid[i]) sh_rank[i]++;
    sh_valid[dest] = 1;
    sh_key[dest] = rq.lookup_key;
    sh_value[dest] = rq.write_value;
    sh_count[dest] = 1;
    sh_rank[dest] = 0;
    sh_occ++;
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Input driver: advance to the next pending item once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_acc) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_reqs.pop_front();
          if (!no_gaps && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      // Output backpressure
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_gaps && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 19);
      end
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    lfu_pkg::rsp_t exp_r;
    bit            active;
    in_acc <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      active = (in_valid_i && in_ready_o) || (cfg_valid_i && cfg_ready_o) ||
               (out_valid_o && out_ready_i);
      if (active) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(cache_access(in_data_i));
      end
      if (out_valid_o && out_ready_i) begin
        responses_seen++;
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected response %h", $time, out_data_o);
        end else begin
          exp_r = expected_rsps.pop_front();
          if (out_data_o.evicted) evictions_seen++;
          if (out_data_o.hit) hits_seen++;
          if (out_data_o.hit !== exp_r.hit) begin
            errors++;
            $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, out_data_o.hit);
          end
          if (out_data_o.read_value !== exp_r.read_value) begin
            errors++;
            $display("%0t: read_value expected %h actual %h", $time,
                     exp_r.read_value, out_data_o.read_value);
          end
          if (out_data_o.evicted !== exp_r.evicted) begin
            errors++;
            $display("%0t: evicted expected %0b actual %0b", $time,
                     exp_r.evicted, out_data_o.evicted);
          end
          if (out_data_o.evicted_key !== exp_r.evicted_key) begin
            errors++;
            $display("%0t: evicted_key expected %h actual %h", $time,
                     exp_r.evicted_key, out_data_o.evicted_key);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic lfu_pkg::req_t make_req(input logic op, input logic [31:0] k,
                                             input logic [31:0] v);
    lfu_pkg::req_t rq;
    rq.opcode = op;
    rq.lookup_key = k;
    rq.write_value = v;
    return rq;
  endfunction

  // Draw a key from a small pool most of the time so hits and evictions occur
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 32'h1000 + $urandom_range(0, 23);
    if (sel == 7) return {$urandom_range(0, 1) ? 8'h80 : 8'h7F, 20'h0, 4'($urandom_range(0, 3))};
    return $urandom;
  endfunction

  task automatic wait_drained();
    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cap_shadow = c;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int i;
    for (i = 0; i < n; i++)
      pending_reqs.push_back(make_req(1'($urandom_range(0, 1)), pick_key(), $urandom));
  endtask

  initial begin
    int i;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_acc = 1'b0;
    cap_shadow = lfu_pkg::CAP_RESET;
    for (i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 0; sh_key[i] = '0; sh_value[i] = '0; sh_count[i] = 0; sh_rank[i] = 0;
    end
    sh_occ = 0;
    errors = 0; responses_seen = 0; evictions_seen = 0; hits_seen = 0;
    idle_cycles = 0; no_gaps = 0; in_gap = 0; out_gap = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, get miss/hit and put update
    pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h8000_0000, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0));
    pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h8000_0000, 32'h0));
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0));
    pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h0, 32'h0));
    wait_drained();
    // Small capacity: victims chosen by lowest count, ties broken by age
    write_capacity(5'd2);
    for (i = 0; i < 6; i++)
      pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h2000 + i, i));
    pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h2005, 32'h0));
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h2100, 32'h1));
    wait_drained();
    // Zero capacity ignores puts but gets still see old entries
    write_capacity(5'd0);
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h2005, 32'h55));
    pending_reqs.push_back(make_req(lfu_pkg::OP_PUT, 32'h3000, 32'h66));
    pending_reqs.push_back(make_req(lfu_pkg::OP_GET, 32'h2005, 32'h0));
    wait_drained();
    // Capacity above the slot count, then lowered below occupancy
    write_capacity(5'd31);
    random_phase(300);
    wait_drained();
    write_capacity(5'd3);
    random_phase(200);
    wait_drained();
    write_capacity(5'd1);
    random_phase(150);
    wait_drained();
    write_capacity(5'd0);
    random_phase(50);
    wait_drained();
    write_capacity(5'd16);
    random_phase(300);
    wait_drained();
    write_capacity(5'd7);
    no_gaps = 1;
    random_phase(200);
    wait_drained();

    $display("Checked %0d responses: %0d hits, %0d evictions over capacities 0..31",
             responses_seen, hits_seen, evictions_seen);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
